[design/rwfs_pkg.sv]
// ----------------------------------------------------------------------------
// rwfs_pkg
// shared constants, widths and request types of the range weighted
// frequency sum block
// ----------------------------------------------------------------------------
package rwfs_pkg;

    // storage sizes
    localparam int ARRAY_DEPTH = 4096;
    localparam int VALUE_RANGE = 65536;

    // fixed field widths of the ports
    localparam int IDX_W  = 12;
    localparam int VAL_W  = 16;
    localparam int RC_W   = 40;

    // derived widths
    localparam int AIDX_W = $clog2(ARRAY_DEPTH);
    localparam int VIDX_W = $clog2(VALUE_RANGE);
    localparam int PTR_W  = $clog2(ARRAY_DEPTH + 1);
    localparam int CNT_W  = PTR_W;
    localparam int FAC_W  = CNT_W + 1;
    localparam int PROD_W = FAC_W + VAL_W;
    localparam int COST_W = RC_W + 1;

    // clearing pass covers both stores
    localparam int CLR_N  = (ARRAY_DEPTH > VALUE_RANGE) ? ARRAY_DEPTH : VALUE_RANGE;
    localparam int CLR_W  = $clog2(CLR_N);

    // kind of a classified request
    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_QUERY  = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    // one queued request
    typedef struct packed {
        kind_t              kind;
        logic [IDX_W-1:0]   idx;
        logic [VAL_W-1:0]   value;
        logic [IDX_W-1:0]   left;
        logic [IDX_W-1:0]   right;
    } item_t;

    // status from the back end to the front end
    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

[design/rwfs_front.sv]
// ----------------------------------------------------------------------------
// rwfs_front
// accepts requests, classifies them and pushes them into the queue
// ----------------------------------------------------------------------------
module rwfs_front (
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      mode,
    input  logic [rwfs_pkg::IDX_W-1:0] elem_index,
    input  logic [rwfs_pkg::VAL_W-1:0] elem_value,
    input  logic [rwfs_pkg::IDX_W-1:0] query_left,
    input  logic [rwfs_pkg::IDX_W-1:0] query_right,
    input  rwfs_pkg::back_status_t    status,
    input  logic                      q_full,
    output logic                      q_push,
    output rwfs_pkg::item_t           q_item
);
    import rwfs_pkg::*;

    logic load_ok;
    logic query_bad;

    // loads outside the store or value range are dropped here
    assign load_ok   = (32'(elem_index) < ARRAY_DEPTH) && (32'(elem_value) < VALUE_RANGE);
    assign query_bad = (query_left > query_right) || (32'(query_right) >= ARRAY_DEPTH);

    assign in_ready = !q_full && !status.clearing;

    always_comb
    begin
        q_item.idx   = elem_index;
        q_item.value = elem_value;
        q_item.left  = query_left;
        q_item.right = query_right;
        if (mode)
        begin
            q_item.kind = query_bad ? KIND_REJECT : KIND_QUERY;
        end
        else
        begin
            q_item.kind = KIND_LOAD;
        end
    end

    assign q_push = in_valid && in_ready && (mode || load_ok);

endmodule

[design/rwfs_queue.sv]
// ----------------------------------------------------------------------------
// rwfs_queue
// two-entry queue between the front and back ends
// ----------------------------------------------------------------------------
module rwfs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rwfs_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output rwfs_pkg::item_t q_item
);
    import rwfs_pkg::*;

    item_t       slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[design/rwfs_back.sv]
// ----------------------------------------------------------------------------
// rwfs_back
// window sequencer: element store, count table, cost update and result
// register
// ----------------------------------------------------------------------------
module rwfs_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  rwfs_pkg::item_t             q_item,
    output logic                        q_pop,
    output rwfs_pkg::back_status_t      status,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rwfs_pkg::RC_W-1:0]   range_cost,
    output logic                        error
);
    import rwfs_pkg::*;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_PLAN  = 8'b0000_0100,
        ST_VAL   = 8'b0000_1000,
        ST_MUL   = 8'b0001_0000,
        ST_ACC   = 8'b0010_0000,
        ST_LDENT = 8'b0100_0000,
        ST_RESP  = 8'b1000_0000
    } state_t;

    // stores
    logic [VAL_W-1:0] elem_mem [ARRAY_DEPTH];
    logic [CNT_W-1:0] cnt_mem  [VALUE_RANGE];
    logic [VAL_W-1:0] elem_rdata_reg;
    logic [CNT_W-1:0] cnt_rdata_reg;

    logic              elem_we;
    logic [AIDX_W-1:0] elem_waddr;
    logic [VAL_W-1:0]  elem_wdata;
    logic              elem_re;
    logic [AIDX_W-1:0] elem_raddr;
    logic              cnt_we;
    logic [VIDX_W-1:0] cnt_waddr;
    logic [CNT_W-1:0]  cnt_wdata;
    logic              cnt_re;
    logic [VIDX_W-1:0] cnt_raddr;

    // control and datapath registers
    state_t              state_reg,     state_next;
    logic [CLR_W-1:0]    clr_reg,       clr_next;
    logic [PTR_W-1:0]    wl_reg,        wl_next;
    logic [PTR_W-1:0]    we_reg,        we_next;
    logic [PTR_W-1:0]    tl_reg,        tl_next;
    logic [PTR_W-1:0]    te_reg,        te_next;
    logic                op_load_reg,   op_load_next;
    logic                ld_phase_reg,  ld_phase_next;
    logic                enter_reg,     enter_next;
    logic                err_reg,       err_next;
    logic [IDX_W-1:0]    ld_idx_reg,    ld_idx_next;
    logic [VAL_W-1:0]    ld_val_reg,    ld_val_next;
    logic [VAL_W-1:0]    v_reg,         v_next;
    logic [PROD_W-1:0]   prod_reg,      prod_next;
    logic [COST_W-1:0]   cost_reg,      cost_next;
    logic                out_valid_reg, out_valid_next;
    logic [RC_W-1:0]     out_cost_reg,  out_cost_next;
    logic                out_err_reg,   out_err_next;

    logic [PTR_W-1:0]    ld_pos;
    logic [FAC_W-1:0]    factor;
    logic [RC_W-1:0]     cost_sat;

    assign ld_pos          = PTR_W'(q_item.idx);
    assign factor          = enter_reg ? {cnt_rdata_reg, 1'b1}
                                       : ({cnt_rdata_reg, 1'b0} - FAC_W'(1));
    assign cost_sat        = (cost_reg[COST_W-1:RC_W] != '0) ? '1 : cost_reg[RC_W-1:0];
    assign status.clearing = (state_reg == ST_CLEAR);
    assign out_valid       = out_valid_reg;
    assign range_cost      = out_cost_reg;
    assign error           = out_err_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        wl_next        = wl_reg;
        we_next        = we_reg;
        tl_next        = tl_reg;
        te_next        = te_reg;
        op_load_next   = op_load_reg;
        ld_phase_next  = ld_phase_reg;
        enter_next     = enter_reg;
        err_next       = err_reg;
        ld_idx_next    = ld_idx_reg;
        ld_val_next    = ld_val_reg;
        v_next         = v_reg;
        prod_next      = prod_reg;
        cost_next      = cost_reg;
        out_valid_next = out_valid_reg;
        out_cost_next  = out_cost_reg;
        out_err_next   = out_err_reg;
        q_pop          = 1'b0;
        elem_we        = 1'b0;
        elem_waddr     = ld_idx_reg[AIDX_W-1:0];
        elem_wdata     = ld_val_reg;
        elem_re        = 1'b0;
        elem_raddr     = wl_reg[AIDX_W-1:0];
        cnt_we         = 1'b0;
        cnt_waddr      = v_reg[VIDX_W-1:0];
        cnt_wdata      = cnt_rdata_reg;
        cnt_re         = 1'b0;
        cnt_raddr      = v_reg[VIDX_W-1:0];

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                if (32'(clr_reg) < VALUE_RANGE)
                begin
                    cnt_we    = 1'b1;
                    cnt_waddr = clr_reg[VIDX_W-1:0];
                    cnt_wdata = '0;
                end
                if (32'(clr_reg) < ARRAY_DEPTH)
                begin
                    elem_we    = 1'b1;
                    elem_waddr = clr_reg[AIDX_W-1:0];
                    elem_wdata = '0;
                end
                clr_next = clr_reg + CLR_W'(1);
                if (32'(clr_reg) == CLR_N - 1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    ld_idx_next = q_item.idx;
                    ld_val_next = q_item.value;
                    case (q_item.kind)
                        KIND_LOAD:
                        begin
                            if ((ld_pos >= wl_reg) && (ld_pos < we_reg))
                            begin
                                // old value leaves first, new value enters after
                                elem_re       = 1'b1;
                                elem_raddr    = q_item.idx[AIDX_W-1:0];
                                op_load_next  = 1'b1;
                                ld_phase_next = 1'b0;
                                enter_next    = 1'b0;
                                state_next    = ST_VAL;
                            end
                            else
                            begin
                                elem_we    = 1'b1;
                                elem_waddr = q_item.idx[AIDX_W-1:0];
                                elem_wdata = q_item.value;
                            end
                        end
                        KIND_QUERY:
                        begin
                            tl_next      = PTR_W'(q_item.left);
                            te_next      = PTR_W'(q_item.right) + PTR_W'(1);
                            op_load_next = 1'b0;
                            err_next     = 1'b0;
                            state_next   = ST_PLAN;
                        end
                        default:
                        begin
                            err_next   = 1'b1;
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_PLAN:
            begin
                // grow both edges before shrinking either
                if (wl_reg > tl_reg)
                begin
                    wl_next    = wl_reg - PTR_W'(1);
                    elem_re    = 1'b1;
                    elem_raddr = wl_next[AIDX_W-1:0];
                    enter_next = 1'b1;
                    state_next = ST_VAL;
                end
                else if (we_reg < te_reg)
                begin
                    we_next    = we_reg + PTR_W'(1);
                    elem_re    = 1'b1;
                    elem_raddr = we_reg[AIDX_W-1:0];
                    enter_next = 1'b1;
                    state_next = ST_VAL;
                end
                else if (wl_reg < tl_reg)
                begin
                    wl_next    = wl_reg + PTR_W'(1);
                    elem_re    = 1'b1;
                    elem_raddr = wl_reg[AIDX_W-1:0];
                    enter_next = 1'b0;
                    state_next = ST_VAL;
                end
                else if (we_reg > te_reg)
                begin
                    we_next    = we_reg - PTR_W'(1);
                    elem_re    = 1'b1;
                    elem_raddr = we_next[AIDX_W-1:0];
                    enter_next = 1'b0;
                    state_next = ST_VAL;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end

            ST_VAL:
            begin
                cnt_re     = 1'b1;
                cnt_raddr  = elem_rdata_reg[VIDX_W-1:0];
                v_next     = elem_rdata_reg;
                state_next = ST_MUL;
            end

            ST_MUL:
            begin
                prod_next  = factor * v_reg;
                cnt_we     = 1'b1;
                cnt_wdata  = enter_reg ? (cnt_rdata_reg + CNT_W'(1))
                                       : (cnt_rdata_reg - CNT_W'(1));
                state_next = ST_ACC;
            end

            ST_ACC:
            begin
                cost_next = enter_reg ? (cost_reg + COST_W'(prod_reg))
                                      : (cost_reg - COST_W'(prod_reg));
                if (!op_load_reg)
                begin
                    state_next = ST_PLAN;
                end
                else if (ld_phase_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_LDENT;
                end
            end

            ST_LDENT:
            begin
                cnt_re        = 1'b1;
                cnt_raddr     = ld_val_reg[VIDX_W-1:0];
                v_next        = ld_val_reg;
                enter_next    = 1'b1;
                ld_phase_next = 1'b1;
                elem_we       = 1'b1;
                state_next    = ST_MUL;
            end

            ST_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_cost_next  = err_reg ? '0 : cost_sat;
                    out_err_next   = err_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            wl_reg        <= '0;
            we_reg        <= '0;
            cost_reg      <= '0;
            op_load_reg   <= 1'b0;
            ld_phase_reg  <= 1'b0;
            enter_reg     <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            wl_reg        <= wl_next;
            we_reg        <= we_next;
            cost_reg      <= cost_next;
            op_load_reg   <= op_load_next;
            ld_phase_reg  <= ld_phase_next;
            enter_reg     <= enter_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tl_reg       <= tl_next;
        te_reg       <= te_next;
        ld_idx_reg   <= ld_idx_next;
        ld_val_reg   <= ld_val_next;
        v_reg        <= v_next;
        prod_reg     <= prod_next;
        out_cost_reg <= out_cost_next;
        out_err_reg  <= out_err_next;
    end

    // element store
    always_ff @(posedge clk)
    begin
        if (elem_we)
        begin
            elem_mem[elem_waddr] <= elem_wdata;
        end
        if (elem_re)
        begin
            elem_rdata_reg <= elem_mem[elem_raddr];
        end
    end

    // per-value count table
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re)
        begin
            cnt_rdata_reg <= cnt_mem[cnt_raddr];
        end
    end

endmodule

[design/range_weighted_frequency_sum_top.sv]
// ----------------------------------------------------------------------------
// range_weighted_frequency_sum_top
// sliding-window sum of count squared times value over an element store
// ----------------------------------------------------------------------------
// The block holds a 4096-entry element store, a 65536-entry table of how
// often each value occurs inside the current window, and the window cost
// (sum over values of count squared times value). A load request writes one
// element and, when its index is inside the window, swaps the old value out
// of the cost and the new one in. A query request walks the window edges one
// element at a time to the requested range and answers with the cost; a
// query with left above right or right beyond the store answers with the
// error flag and a zero cost, leaving the window as it was. After reset the
// block runs a clearing pass over both stores and takes no request until it
// ends. The sequencer visits the element store, then the count table, then
// the multiplier, then the cost adder for every element that enters or
// leaves. A query also waits while an earlier result is still unread in the
// output register. A two-entry queue lets up to two requests wait while the
// sequencer works, and a finished result waits in the output register
// without holding up later loads.
// ----------------------------------------------------------------------------
module range_weighted_frequency_sum_top (
    input  logic                        clk,
    input  logic                        rst_n,
    // request channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        mode,
    input  logic [rwfs_pkg::IDX_W-1:0]  elem_index,
    input  logic [rwfs_pkg::VAL_W-1:0]  elem_value,
    input  logic [rwfs_pkg::IDX_W-1:0]  query_left,
    input  logic [rwfs_pkg::IDX_W-1:0]  query_right,
    // result channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rwfs_pkg::RC_W-1:0]   range_cost,
    output logic                        error
);
    import rwfs_pkg::*;

    // front end to queue
    logic         q_push;
    item_t        push_item;
    logic         q_full;
    // queue to back end
    logic         q_pop;
    logic         q_valid;
    item_t        q_item;
    // back end status seen by the front end
    back_status_t status;

    // classifies requests, drops loads that fall outside the stores
    rwfs_front u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .elem_index  (elem_index),
        .elem_value  (elem_value),
        .query_left  (query_left),
        .query_right (query_right),
        .status      (status),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (push_item)
    );

    // decouples acceptance from the window walk
    rwfs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    // window sequencer with both stores and the result register
    rwfs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .status     (status),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .range_cost (range_cost),
        .error      (error)
    );

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the range weighted frequency sum block
// ----------------------------------------------------------------------------
// A queue of pending requests is filled up front with a short directed set
// and then a few hundred random loads and queries. A clocked driver offers
// them with random gaps. A clocked monitor takes the results with random
// stalls and one long hold-off. Every accepted request is run through a
// local copy of the element store, the value count table and the sliding
// window. Each query leaves its expected cost in a queue, and the monitor
// checks every result against the oldest entry of that queue.
// ----------------------------------------------------------------------------
module testbench;

    import rwfs_pkg::*;

    localparam int CLK_PERIOD      = 4;
    localparam int RESET_CYCLES    = 12;
    localparam int RANDOM_REQUESTS = 400;
    // long receiver hold-off, big enough to fill the two-entry queue and
    // the output register so that the request side backs up
    localparam int HOLD_CYCLES     = 3000;
    localparam int HOLD_AFTER      = 50;
    // loads give no result
    localparam int DRAIN_CYCLES    = 64;
    // clearing pass or a query that walks both edges over the whole store,
    // with margin
    localparam int WATCHDOG_LIMIT  = 300000;
    localparam logic [63:0] COST_CAP = (64'd1 << RC_W) - 64'd1;

    // one request as the sender sees it, with the gap to wait before it
    typedef struct {
        logic              mode;
        logic [IDX_W-1:0]  idx;
        logic [VAL_W-1:0]  value;
        logic [IDX_W-1:0]  q_lo;
        logic [IDX_W-1:0]  q_hi;
        int unsigned       gap;
    } request_t;

    // one expected result
    typedef struct {
        logic [RC_W-1:0]   cost;
        logic              err;
    } answer_t;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    logic              mode        = 1'b0;
    logic [IDX_W-1:0]  elem_index  = '0;
    logic [VAL_W-1:0]  elem_value  = '0;
    logic [IDX_W-1:0]  query_left  = '0;
    logic [IDX_W-1:0]  query_right = '0;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    logic [RC_W-1:0]   range_cost;
    logic              error;

    range_weighted_frequency_sum_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .elem_index  (elem_index),
        .elem_value  (elem_value),
        .query_left  (query_left),
        .query_right (query_right),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .range_cost  (range_cost),
        .error       (error)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // local copy of the block state
    // ------------------------------------------------------------------
    logic [VAL_W-1:0]  elem_mirror [ARRAY_DEPTH];
    int unsigned       value_count [VALUE_RANGE];
    int                win_lo      = 0;
    int                win_hi      = -1;    // empty window after reset
    longint unsigned   window_cost = 0;

    request_t          request_backlog [$];
    answer_t           pending_costs [$];
    request_t          offered;

    int                total_requests    = 0;
    int                accepted_requests = 0;
    int                answers_due       = 0;
    int                results_seen      = 0;
    int                mismatches        = 0;
    int                idle_cycles       = 0;
    bit                quiet_tx          = 1'b0;

    // one element of value v enters the window
    function void count_in(logic [VAL_W-1:0] v);
        longint unsigned f;
        f = 64'(value_count[v]);
        window_cost = window_cost + (2 * f + 1) * v;
        value_count[v] = 32'(f + 1);
    endfunction

    // one element of value v leaves the window
    function void count_out(logic [VAL_W-1:0] v);
        longint unsigned f;
        f = 64'(value_count[v]);
        if (f != 0)
        begin
            window_cost = window_cost - (2 * f - 1) * v;
            value_count[v] = 32'(f - 1);
        end
    endfunction

    // apply one accepted request to the local state and queue its answer
    function void apply_request(request_t r);
        kind_t    kind;
        int       lo;
        int       hi;
        int       i;
        answer_t  ans;
        lo = int'(r.q_lo);
        hi = int'(r.q_hi);
        i  = int'(r.idx);
        if (r.mode == 1'b0)
            kind = KIND_LOAD;
        else if (lo > hi || hi >= ARRAY_DEPTH)
            kind = KIND_REJECT;
        else
            kind = KIND_QUERY;
        case (kind)
            KIND_LOAD:
            begin
                // a load inside the window swaps the old value for the new
                if (i >= win_lo && i <= win_hi)
                begin
                    count_out(elem_mirror[i]);
                    count_in(r.value);
                end
                elem_mirror[i] = r.value;
            end
            KIND_REJECT:
            begin
                ans.cost = '0;
                ans.err  = 1'b1;
                pending_costs = {pending_costs, ans};
                answers_due++;
            end
            default:
            begin
                // grow both edges first, then shrink
                while (win_lo > lo)
                begin
                    win_lo--;
                    count_in(elem_mirror[win_lo]);
                end
                while (win_hi < hi)
                begin
                    win_hi++;
                    count_in(elem_mirror[win_hi]);
                end
                while (win_lo < lo)
                begin
                    count_out(elem_mirror[win_lo]);
                    win_lo++;
                end
                while (win_hi > hi)
                begin
                    count_out(elem_mirror[win_hi]);
                    win_hi--;
                end
                ans.cost = (window_cost > COST_CAP) ? COST_CAP[RC_W-1:0]
                                                    : window_cost[RC_W-1:0];
                ans.err  = 1'b0;
                pending_costs = {pending_costs, ans};
                answers_due++;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // request builders: fields the block ignores get random content
    // ------------------------------------------------------------------
    function int clip(int v);
        return (v < 0) ? 0 : ((v > ARRAY_DEPTH - 1) ? ARRAY_DEPTH - 1 : v);
    endfunction

    function void queue_load(int idx, int val);
        request_t r;
        r.mode  = 1'b0;
        r.idx   = idx[IDX_W-1:0];
        r.value = val[VAL_W-1:0];
        r.q_lo  = IDX_W'($urandom_range(0, ARRAY_DEPTH - 1));
        r.q_hi  = IDX_W'($urandom_range(0, ARRAY_DEPTH - 1));
        r.gap   = quiet_tx ? 0 : $urandom_range(0, 19);
        request_backlog = {request_backlog, r};
        total_requests++;
    endfunction

    function void queue_query(int lo, int hi);
        request_t r;
        r.mode  = 1'b1;
        r.idx   = IDX_W'($urandom_range(0, ARRAY_DEPTH - 1));
        r.value = VAL_W'($urandom_range(0, VALUE_RANGE - 1));
        r.q_lo  = lo[IDX_W-1:0];
        r.q_hi  = hi[IDX_W-1:0];
        r.gap   = quiet_tx ? 0 : $urandom_range(0, 19);
        request_backlog = {request_backlog, r};
        total_requests++;
    endfunction

    // ------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int                n;
        int                pick;
        int                sel;
        int                lo;
        int                hi;
        int                tmp;
        int                val;
        int                gen_lo;
        int                gen_hi;
        logic [VAL_W-1:0]  hot [8];

        for (n = 0; n < ARRAY_DEPTH; n++)
            elem_mirror[n] = '0;
        for (n = 0; n < VALUE_RANGE; n++)
            value_count[n] = 0;

        // directed part
        queue_query(0, 0);              // first query from the empty window
        queue_query(5, 3);              // left above right
        queue_query(4095, 0);           // left above right, extreme indices
        queue_load(0, 65535);
        queue_load(4095, 65535);
        queue_load(1, 65535);
        queue_load(2, 0);
        queue_query(0, 4095);           // whole store
        queue_load(1, 1);               // swap inside the window
        queue_load(4095, 65535);        // same value rewritten inside
        queue_query(4095, 4095);        // left edge sweeps the whole store
        queue_query(0, 2);              // both edges sweep back
        queue_query(1, 1);              // shrink from both sides
        queue_query(3, 3);              // disjoint window above
        queue_query(0, 0);              // disjoint window below
        queue_load(2730, 43690);        // alternating bits, outside
        queue_load(1365, 21845);
        queue_query(1, 1);
        queue_query(4095, 4094);        // rejected by one
        queue_query(0, 0);              // no movement after a reject
        queue_query(0, 1);
        gen_lo = 0;
        gen_hi = 1;

        // a few hot values so that counts grow above one
        hot[0] = 16'd0;
        hot[1] = 16'd1;
        hot[2] = 16'hFFFF;
        hot[3] = 16'd3;
        for (n = 4; n < 8; n++)
            hot[n] = VAL_W'($urandom_range(0, VALUE_RANGE - 1));

        // random part: mostly small window moves with random content
        for (n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % 40 == 0)
                quiet_tx = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 9) < 6)
                val = int'(hot[$urandom_range(0, 7)]);
            else
                val = $urandom_range(0, VALUE_RANGE - 1);
            if (pick < 45)
            begin
                sel = $urandom_range(0, 19);
                if (sel < 10)
                    lo = $urandom_range(gen_lo, gen_hi);
                else if (sel < 17)
                    lo = $urandom_range(0, 255);
                else
                    lo = $urandom_range(0, ARRAY_DEPTH - 1);
                queue_load(lo, val);
            end
            else if (pick < 88)
            begin
                lo = clip(gen_lo + int'($urandom_range(0, 32)) - 16);
                hi = clip(gen_hi + int'($urandom_range(0, 32)) - 16);
                if (lo > hi)
                begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
                // keep windows narrow so that the walks stay short
                if (hi - lo > 300)
                    hi = lo + int'($urandom_range(0, 300));
                queue_query(lo, hi);
                gen_lo = lo;
                gen_hi = hi;
            end
            else if (pick < 90)
            begin
                lo = $urandom_range(0, ARRAY_DEPTH - 1);
                hi = clip(lo + int'($urandom_range(0, 63)));
                queue_query(lo, hi);
                gen_lo = lo;
                gen_hi = hi;
            end
            else if (pick < 97)
            begin
                lo = $urandom_range(1, ARRAY_DEPTH - 1);
                hi = $urandom_range(0, lo - 1);
                queue_query(lo, hi);
            end
            else
            begin
                lo = $urandom_range(0, ARRAY_DEPTH - 1);
                hi = $urandom_range(0, ARRAY_DEPTH - 1);
                queue_query(lo, hi);
                if (lo <= hi)
                begin
                    gen_lo = lo;
                    gen_hi = hi;
                end
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // all requests taken, all answers in, then let a trailing load settle
        wait (accepted_requests == total_requests);
        wait (results_seen == answers_due);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // driver: offers the backlog, holding valid and payload until taken
    // ------------------------------------------------------------------
    int unsigned wait_cnt = 0;

    always @(posedge clk or negedge rst_n)
    begin
        request_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            wait_cnt <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                apply_request(offered);
                accepted_requests++;
            end
            if (in_valid && !in_ready)
            begin
                // request still waiting, payload stays put
            end
            else if (request_backlog.size() == 0)
                in_valid <= 1'b0;
            else if (wait_cnt < request_backlog[0].gap)
            begin
                in_valid <= 1'b0;
                wait_cnt <= wait_cnt + 1;
            end
            else
            begin
                nxt = request_backlog.pop_front();
                offered     <= nxt;
                mode        <= nxt.mode;
                elem_index  <= nxt.idx;
                elem_value  <= nxt.value;
                query_left  <= nxt.q_lo;
                query_right <= nxt.q_hi;
                in_valid    <= 1'b1;
                wait_cnt    <= 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: takes results with random stalls and checks them
    // ------------------------------------------------------------------
    int unsigned stall_cnt = 0;
    int unsigned hold_cnt  = 0;
    bit          hold_done = 1'b0;
    bit          quiet_rx  = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        answer_t      want;
        bit           took;
        int unsigned  s;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_cnt <= 0;
            hold_cnt  <= 0;
        end
        else
        begin
            took = out_valid && out_ready;
            if (took)
            begin
                results_seen++;
                if (pending_costs.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: cost %0d error %0b",
                                 range_cost, error);
                end
                else
                begin
                    want = pending_costs.pop_front();
                    if (want.cost !== range_cost || want.err !== error)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected %0d/%0b, got %0d/%0b",
                                     results_seen, want.cost, want.err, range_cost, error);
                    end
                end
                // switch between stalling and stall-free stretches now and then
                if (results_seen % 25 == 0)
                    quiet_rx = ($urandom_range(0, 2) == 0);
            end

            if (hold_cnt != 0)
            begin
                hold_cnt  <= hold_cnt - 1;
                out_ready <= 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                // long hold-off while the sender keeps going
                hold_done = 1'b1;
                hold_cnt  <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (took)
            begin
                s = quiet_rx ? 0 : $urandom_range(0, 19);
                stall_cnt <= s;
                out_ready <= (s == 0);
            end
            else if (stall_cnt != 0)
            begin
                stall_cnt <= stall_cnt - 1;
                out_ready <= (stall_cnt == 1);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any request or result taken
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
